### sv/bertlv_pkg.sv
`timescale 1ns / 1ps
// Shared constants, field codes and controller/datapath interface types of the BER TLV encoder.
package bertlv_pkg;

    // Field widths.
    localparam int LENGTH_BITS = 24;
    localparam int TAG_BITS    = 32;
    localparam int INT_BITS    = 63;

    // Derived sizes.
    localparam int TAG_GROUPS  = (TAG_BITS + 6) / 7;
    localparam int TOTAL_BITS  = LENGTH_BITS + 1;
    localparam int TOTAL_BYTES = (TOTAL_BITS + 7) / 8;
    localparam int SLEN_BYTES  = (LENGTH_BITS + 7) / 8;
    localparam int INT_BYTES   = (INT_BITS + 1) / 8;
    localparam int CNT_W       = $clog2(INT_BYTES + 1);

    // Value kinds.
    localparam logic [1:0] KIND_NULL   = 2'd0;
    localparam logic [1:0] KIND_INT    = 2'd1;
    localparam logic [1:0] KIND_STRING = 2'd2;
    localparam logic [1:0] KIND_UNDEF  = 2'd3;

    // Tagging codes. The fourth code has no meaning of its own and behaves as untagged.
    localparam logic [1:0] TAGGING_NONE     = 2'd0;
    localparam logic [1:0] TAGGING_IMPLICIT = 2'd1;
    localparam logic [1:0] TAGGING_EXPLICIT = 2'd2;
    localparam logic [1:0] TAGGING_UNUSED   = 2'd3;

    // Identifier and length octet constants.
    localparam logic [4:0] TAG_ESC       = 5'h1f;
    localparam logic [7:0] ID_NULL       = 8'h05;
    localparam logic [7:0] ID_INTEGER    = 8'h02;
    localparam logic [7:0] ID_OCTETS     = 8'h04;
    localparam logic [7:0] LEN_LONG_FORM = 8'h80;
    localparam logic [7:0] SHORT_LIMIT   = 8'h80;

    // Which byte of the encoding the datapath drives.
    typedef enum logic [3:0] {
        SEL_DATA,
        SEL_TAG,
        SEL_TAG_GRP,
        SEL_OLEN,
        SEL_OLEN_BYTE,
        SEL_ITAG,
        SEL_ILEN,
        SEL_ILEN_BYTE,
        SEL_ICONT
    } sel_t;

    typedef struct packed {
        logic             capture;
        logic             prep_cnt;
        logic             prep_tot;
        logic             emit;
        sel_t             sel;
        logic [CNT_W-1:0] cnt;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic             out_free;
        logic             rem_zero;
        logic [1:0]       kind;
        logic [1:0]       tagging;
        logic [CNT_W-1:0] groups;
        logic [CNT_W-1:0] int_n;
        logic [CNT_W-1:0] slen_nb;
        logic [CNT_W-1:0] olen_nb;
    } sts_t;

endpackage

### sv/bertlv_dp.sv
`timescale 1ns / 1ps
// Datapath of the BER TLV encoder: captured fields, byte counts, remainder and output register.
module bertlv_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  bertlv_pkg::cmd_t                   cmd,
    output bertlv_pkg::sts_t                   sts,
    input  logic [1:0]                         s_value_kind,
    input  logic [1:0]                         s_tagging,
    input  logic [1:0]                         s_tag_class,
    input  logic [bertlv_pkg::TAG_BITS-1:0]    s_tag_number,
    input  logic [bertlv_pkg::INT_BITS-1:0]    s_int_value,
    input  logic [bertlv_pkg::LENGTH_BITS-1:0] s_string_length,
    input  logic [7:0]                         s_data_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_out_byte,
    output logic                               m_last_of_run,
    output logic                               m_end_of_value
);

    localparam int CW = bertlv_pkg::CNT_W;
    localparam int TB = bertlv_pkg::TAG_BITS;
    localparam int LB = bertlv_pkg::LENGTH_BITS;
    localparam int IB = bertlv_pkg::INT_BITS;
    localparam int OB = bertlv_pkg::TOTAL_BITS;

    // Number of base-128 groups after the escape octet, zero for the one-octet form.
    function automatic logic [CW-1:0] tag_groups(input logic [TB-1:0] num);
        logic [CW-1:0] g;
        g = '0;
        if (num >= TB'(bertlv_pkg::TAG_ESC)) begin
            g = CW'(1);
            for (int k = 1; k < bertlv_pkg::TAG_GROUPS; k++) begin
                if ((num >> (7 * k)) != '0) begin
                    g = CW'(k + 1);
                end
            end
        end
        return g;
    endfunction

    // Minimal two's-complement octet count of a non-negative integer.
    function automatic logic [CW-1:0] int_octets(input logic [IB-1:0] v);
        logic [CW-1:0] n;
        n = CW'(1);
        for (int k = 1; k < bertlv_pkg::INT_BYTES; k++) begin
            if ((v >> (8 * k - 1)) != '0) begin
                n = CW'(k + 1);
            end
        end
        return n;
    endfunction

    // Long-form length octet counts, zero when the short form applies.
    function automatic logic [CW-1:0] slen_octets(input logic [LB-1:0] v);
        logic [CW-1:0] n;
        n = '0;
        if (v >= LB'(bertlv_pkg::SHORT_LIMIT)) begin
            n = CW'(1);
            for (int k = 1; k < bertlv_pkg::SLEN_BYTES; k++) begin
                if ((v >> (8 * k)) != '0) begin
                    n = CW'(k + 1);
                end
            end
        end
        return n;
    endfunction

    function automatic logic [CW-1:0] tot_octets(input logic [OB-1:0] v);
        logic [CW-1:0] n;
        n = '0;
        if (v >= OB'(bertlv_pkg::SHORT_LIMIT)) begin
            n = CW'(1);
            for (int k = 1; k < bertlv_pkg::TOTAL_BYTES; k++) begin
                if ((v >> (8 * k)) != '0) begin
                    n = CW'(k + 1);
                end
            end
        end
        return n;
    endfunction

    // Byte and group pickers, indexed from the least significant end.
    function automatic logic [6:0] pick_grp(input logic [TB-1:0] v, input logic [CW-1:0] idx);
        logic [6:0] r;
        r = '0;
        for (int k = 0; k < bertlv_pkg::TAG_GROUPS; k++) begin
            if (idx == CW'(k)) begin
                r = 7'(v >> (7 * k));
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] pick_tot(input logic [OB-1:0] v, input logic [CW-1:0] idx);
        logic [7:0] r;
        r = '0;
        for (int k = 0; k < bertlv_pkg::TOTAL_BYTES; k++) begin
            if (idx == CW'(k)) begin
                r = 8'(v >> (8 * k));
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] pick_slen(input logic [LB-1:0] v, input logic [CW-1:0] idx);
        logic [7:0] r;
        r = '0;
        for (int k = 0; k < bertlv_pkg::SLEN_BYTES; k++) begin
            if (idx == CW'(k)) begin
                r = 8'(v >> (8 * k));
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] pick_int(input logic [IB-1:0] v, input logic [CW-1:0] idx);
        logic [7:0] r;
        r = '0;
        for (int k = 0; k < bertlv_pkg::INT_BYTES; k++) begin
            if (idx == CW'(k)) begin
                r = 8'(v >> (8 * k));
            end
        end
        return r;
    endfunction

    logic [1:0]    kind_reg, kind_next;
    logic [1:0]    tagging_reg, tagging_next;
    logic [1:0]    cls_reg, cls_next;
    logic [TB-1:0] tnum_reg, tnum_next;
    logic [IB-1:0] ival_reg, ival_next;
    logic [LB-1:0] slen_reg, slen_next;
    logic [CW-1:0] groups_reg, groups_next;
    logic [CW-1:0] int_n_reg, int_n_next;
    logic [CW-1:0] slen_nb_reg, slen_nb_next;
    logic [OB-1:0] tot_reg, tot_next;
    logic [LB-1:0] rem_reg, rem_next;
    logic          valid_reg, valid_next;
    logic [7:0]    byte_reg, byte_next;
    logic          last_reg, last_next;
    logic          eov_reg, eov_next;

    logic [CW-1:0] olen_nb;
    logic [CW-1:0] idx;
    logic          open_string;
    logic [7:0]    emit_byte;
    logic [7:0]    id_bits;

    assign olen_nb     = tot_octets(tot_reg);
    assign idx         = cmd.cnt - CW'(1);
    assign open_string = (kind_reg == bertlv_pkg::KIND_STRING) && (slen_reg != '0);
    assign id_bits     = {cls_reg, tagging_reg == bertlv_pkg::TAGGING_EXPLICIT, 5'b0};

    always_comb begin
        emit_byte = s_data_byte;
        case (cmd.sel)
            bertlv_pkg::SEL_DATA: begin
                emit_byte = s_data_byte;
            end
            bertlv_pkg::SEL_TAG: begin
                emit_byte = id_bits | {3'b0, (groups_reg == '0) ? tnum_reg[4:0]
                                                                 : bertlv_pkg::TAG_ESC};
            end
            bertlv_pkg::SEL_TAG_GRP: begin
                emit_byte = {cmd.cnt != CW'(1), pick_grp(tnum_reg, idx)};
            end
            bertlv_pkg::SEL_OLEN: begin
                emit_byte = (olen_nb == '0) ? {1'b0, tot_reg[6:0]}
                                            : (bertlv_pkg::LEN_LONG_FORM | 8'(olen_nb));
            end
            bertlv_pkg::SEL_OLEN_BYTE: begin
                emit_byte = pick_tot(tot_reg, idx);
            end
            bertlv_pkg::SEL_ITAG: begin
                case (kind_reg)
                    bertlv_pkg::KIND_INT:    emit_byte = bertlv_pkg::ID_INTEGER;
                    bertlv_pkg::KIND_STRING: emit_byte = bertlv_pkg::ID_OCTETS;
                    default:                 emit_byte = bertlv_pkg::ID_NULL;
                endcase
            end
            bertlv_pkg::SEL_ILEN: begin
                case (kind_reg)
                    bertlv_pkg::KIND_INT: begin
                        emit_byte = 8'(int_n_reg);
                    end
                    bertlv_pkg::KIND_STRING: begin
                        emit_byte = (slen_nb_reg == '0) ? {1'b0, slen_reg[6:0]}
                                    : (bertlv_pkg::LEN_LONG_FORM | 8'(slen_nb_reg));
                    end
                    default: begin
                        emit_byte = 8'h00;
                    end
                endcase
            end
            bertlv_pkg::SEL_ILEN_BYTE: begin
                emit_byte = pick_slen(slen_reg, idx);
            end
            bertlv_pkg::SEL_ICONT: begin
                emit_byte = pick_int(ival_reg, idx);
            end
            default: begin
                emit_byte = s_data_byte;
            end
        endcase
    end

    always_comb begin
        kind_next    = kind_reg;
        tagging_next = tagging_reg;
        cls_next     = cls_reg;
        tnum_next    = tnum_reg;
        ival_next    = ival_reg;
        slen_next    = slen_reg;
        groups_next  = groups_reg;
        int_n_next   = int_n_reg;
        slen_nb_next = slen_nb_reg;
        tot_next     = tot_reg;
        rem_next     = rem_reg;
        valid_next   = valid_reg && !m_ready;
        byte_next    = byte_reg;
        last_next    = last_reg;
        eov_next     = eov_reg;

        if (cmd.capture) begin
            kind_next    = s_value_kind;
            // Tagging code three behaves as untagged.
            tagging_next = (s_tagging == bertlv_pkg::TAGGING_UNUSED) ? bertlv_pkg::TAGGING_NONE
                                                                      : s_tagging;
            cls_next     = s_tag_class;
            tnum_next    = s_tag_number;
            ival_next    = s_int_value;
            slen_next    = s_string_length;
            rem_next     = (s_value_kind == bertlv_pkg::KIND_STRING) ? s_string_length : '0;
        end

        if (cmd.prep_cnt) begin
            groups_next  = tag_groups(tnum_reg);
            int_n_next   = int_octets(ival_reg);
            slen_nb_next = slen_octets(slen_reg);
        end

        if (cmd.prep_tot) begin
            case (kind_reg)
                bertlv_pkg::KIND_INT:    tot_next = OB'(2) + OB'(int_n_reg);
                bertlv_pkg::KIND_STRING: tot_next = OB'(2) + OB'(slen_nb_reg) + OB'(slen_reg);
                default:                 tot_next = OB'(2);
            endcase
        end

        if (cmd.emit) begin
            valid_next = 1'b1;
            byte_next  = emit_byte;
            last_next  = cmd.last;
            if (cmd.sel == bertlv_pkg::SEL_DATA) begin
                rem_next = rem_reg - LB'(1);
                eov_next = (rem_reg == LB'(1));
            end else begin
                eov_next = cmd.last && !open_string;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            rem_reg   <= rem_next;
            valid_reg <= valid_next;
        end
        kind_reg    <= kind_next;
        tagging_reg <= tagging_next;
        cls_reg     <= cls_next;
        tnum_reg    <= tnum_next;
        ival_reg    <= ival_next;
        slen_reg    <= slen_next;
        groups_reg  <= groups_next;
        int_n_reg   <= int_n_next;
        slen_nb_reg <= slen_nb_next;
        tot_reg     <= tot_next;
        byte_reg    <= byte_next;
        last_reg    <= last_next;
        eov_reg     <= eov_next;
    end

    always_comb begin
        sts.out_free = !valid_reg || m_ready;
        sts.rem_zero = (rem_reg == '0);
        sts.kind     = kind_reg;
        sts.tagging  = tagging_reg;
        sts.groups   = groups_reg;
        sts.int_n    = int_n_reg;
        sts.slen_nb  = slen_nb_reg;
        sts.olen_nb  = olen_nb;
    end

    assign m_valid        = valid_reg;
    assign m_out_byte     = byte_reg;
    assign m_last_of_run  = last_reg;
    assign m_end_of_value = eov_reg;

endmodule

### sv/bertlv_ctrl.sv
`timescale 1ns / 1ps
// Controller of the BER TLV encoder: sequences identifier, length and content bytes.
module bertlv_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_mode,
    input  logic [1:0]       s_value_kind,
    input  bertlv_pkg::sts_t sts,
    output bertlv_pkg::cmd_t cmd
);

    localparam int CW = bertlv_pkg::CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP_CNT,
        ST_PREP_TOT,
        ST_TAG,
        ST_TAG_GRP,
        ST_OLEN,
        ST_OLEN_BYTE,
        ST_ITAG,
        ST_ILEN,
        ST_ILEN_BYTE,
        ST_ICONT
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    state_t        after_tag;

    // Explicit tagging goes on to the outer length; implicit skips the universal identifier.
    assign after_tag = (sts.tagging == bertlv_pkg::TAGGING_EXPLICIT) ? ST_OLEN : ST_ILEN;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        s_ready      = 1'b0;
        cmd.capture  = 1'b0;
        cmd.prep_cnt = 1'b0;
        cmd.prep_tot = 1'b0;
        cmd.emit     = 1'b0;
        cmd.sel      = bertlv_pkg::SEL_DATA;
        cmd.cnt      = cnt_reg;
        cmd.last     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = sts.out_free;
                if (s_valid && sts.out_free) begin
                    if (s_mode) begin
                        // Content byte; dropped when no string is open.
                        cmd.emit = !sts.rem_zero;
                        cmd.last = 1'b1;
                    end else begin
                        cmd.capture = 1'b1;
                        if (s_value_kind != bertlv_pkg::KIND_UNDEF) begin
                            state_next = ST_PREP_CNT;
                        end
                    end
                end
            end
            ST_PREP_CNT: begin
                cmd.prep_cnt = 1'b1;
                state_next   = ST_PREP_TOT;
            end
            ST_PREP_TOT: begin
                cmd.prep_tot = 1'b1;
                state_next   = (sts.tagging != bertlv_pkg::TAGGING_NONE) ? ST_TAG : ST_ITAG;
            end
            ST_TAG: begin
                cmd.sel  = bertlv_pkg::SEL_TAG;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    if (sts.groups != '0) begin
                        state_next = ST_TAG_GRP;
                        cnt_next   = sts.groups;
                    end else begin
                        state_next = after_tag;
                    end
                end
            end
            ST_TAG_GRP: begin
                cmd.sel  = bertlv_pkg::SEL_TAG_GRP;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    cnt_next = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_next = after_tag;
                    end
                end
            end
            ST_OLEN: begin
                cmd.sel  = bertlv_pkg::SEL_OLEN;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    if (sts.olen_nb != '0) begin
                        state_next = ST_OLEN_BYTE;
                        cnt_next   = sts.olen_nb;
                    end else begin
                        state_next = ST_ITAG;
                    end
                end
            end
            ST_OLEN_BYTE: begin
                cmd.sel  = bertlv_pkg::SEL_OLEN_BYTE;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    cnt_next = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_next = ST_ITAG;
                    end
                end
            end
            ST_ITAG: begin
                cmd.sel  = bertlv_pkg::SEL_ITAG;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_ILEN;
                end
            end
            ST_ILEN: begin
                cmd.sel  = bertlv_pkg::SEL_ILEN;
                cmd.emit = sts.out_free;
                case (sts.kind)
                    bertlv_pkg::KIND_INT: begin
                        if (sts.out_free) begin
                            state_next = ST_ICONT;
                            cnt_next   = sts.int_n;
                        end
                    end
                    bertlv_pkg::KIND_STRING: begin
                        cmd.last = (sts.slen_nb == '0);
                        if (sts.out_free) begin
                            if (sts.slen_nb != '0) begin
                                state_next = ST_ILEN_BYTE;
                                cnt_next   = sts.slen_nb;
                            end else begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    default: begin
                        cmd.last = 1'b1;
                        if (sts.out_free) begin
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_ILEN_BYTE: begin
                cmd.sel  = bertlv_pkg::SEL_ILEN_BYTE;
                cmd.emit = sts.out_free;
                cmd.last = (cnt_reg == CW'(1));
                if (sts.out_free) begin
                    cnt_next = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ICONT: begin
                cmd.sel  = bertlv_pkg::SEL_ICONT;
                cmd.emit = sts.out_free;
                cmd.last = (cnt_reg == CW'(1));
                if (sts.out_free) begin
                    cnt_next = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### sv/ber_tlv_value_encoder.sv
`timescale 1ns / 1ps
// Top level of the BER TLV encoder for NULL, INTEGER and OCTET STRING values.
//
// This block turns a start request (mode 0) into the ASN.1 BER bytes of one value: identifier
// octets (one octet for tag numbers below 31, otherwise the escape octet and base-128 groups),
// length octets in short or long form, and for an INTEGER its minimal two's-complement content.
// Implicit tagging replaces the universal identifier with the given class and number; explicit
// tagging wraps the universal encoding in a constructed outer identifier and length. For an
// OCTET STRING the content arrives afterwards as byte requests (mode 1), each passed straight
// through as one result byte while a stored remainder counts down; a byte request with no open
// string is dropped, and a new start abandons an unfinished string. Value kind three yields
// nothing. After it is accepted, a start request first prepares the byte counts, then the outer
// length, and then emits its bytes one by one through the single output register, up to 17
// bytes for an explicitly tagged eight-octet integer with a five-group tag number; the block
// accepts no new request until the last header byte is loaded. While the output register is
// free to take each byte, string content streams at one byte per cycle. The output register
// separates the two channels: a new request is taken in the same cycle that a waiting result
// is taken downstream. last_of_run marks the final byte caused by a request and end_of_value
// the final byte of the whole encoded value (for an empty string, the last header byte).
module ber_tlv_value_encoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_mode,
    input  logic [1:0]                         s_value_kind,
    input  logic [1:0]                         s_tagging,
    input  logic [1:0]                         s_tag_class,
    input  logic [bertlv_pkg::TAG_BITS-1:0]    s_tag_number,
    input  logic [bertlv_pkg::INT_BITS-1:0]    s_int_value,
    input  logic [bertlv_pkg::LENGTH_BITS-1:0] s_string_length,
    input  logic [7:0]                         s_data_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_out_byte,
    output logic                               m_last_of_run,
    output logic                               m_end_of_value
);

    // Commands from the controller and status back from the datapath.
    bertlv_pkg::cmd_t cmd;
    bertlv_pkg::sts_t sts;

    // The controller owns the request handshake and the byte sequence.
    bertlv_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_value_kind (s_value_kind),
        .sts          (sts),
        .cmd          (cmd)
    );

    // The datapath holds the captured request, the octet counts, the string remainder and the
    // output register that drives the result channel.
    bertlv_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_value_kind    (s_value_kind),
        .s_tagging       (s_tagging),
        .s_tag_class     (s_tag_class),
        .s_tag_number    (s_tag_number),
        .s_int_value     (s_int_value),
        .s_string_length (s_string_length),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last_of_run   (m_last_of_run),
        .m_end_of_value  (m_end_of_value)
    );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the BER TLV value encoder with a scoreboard class and request drivers.

module testbench;
    import bertlv_pkg::*;

    // Request modes on the input channel.
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_CONTENT = 1'b1;

    // Constructed bit of an identifier octet, used by the explicit outer tag.
    localparam logic [7:0] ID_CONSTRUCTED = 8'h20;

    // Counted requests at which the random part ends, and the point after which idling stops.
    localparam int RANDOM_TARGET = 400;
    localparam int CALM_POINT    = 330;

    // Hard limit on the run. The slowest legal run (every start producing its longest
    // header, every byte held by the longest receiver stall) stays far below this.
    localparam int RUN_LIMIT = 400000;

    // One byte of the encoding as it leaves the block.
    typedef struct packed {
        logic [7:0] octet;
        logic       run_end;
        logic       value_end;
    } ber_byte_t;

    typedef logic [7:0] octet_q_t[$];

    // The scoreboard holds its own copy of the open-string counter and predicts the
    // encoded bytes of each accepted request. Results are checked strictly in order.
    class ber_scoreboard;
        logic [23:0] content_left;
        ber_byte_t   expected_q[$];
        int          mismatches;
        int          checked;
        int          starts;
        int          content_bytes;
        int          dropped;
        int          undefined_kinds;

        function new();
            content_left    = '0;
            mismatches      = 0;
            checked         = 0;
            starts          = 0;
            content_bytes   = 0;
            dropped         = 0;
            undefined_kinds = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int counted();
            return starts + content_bytes + undefined_kinds;
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("MISMATCH: %s", what);
            end
        endfunction

        // Identifier octets: a single octet below 31, otherwise the escape and base-128 groups.
        function octet_q_t tag_octets(logic [7:0] lead, logic [31:0] num);
            octet_q_t   q;
            int         groups;
            logic [7:0] grp;
            if (num < 31) begin
                q = {q, lead | {3'b000, num[4:0]}};
                return q;
            end
            q = {q, lead | {3'b000, TAG_ESC}};
            groups = 1;
            while (groups < 5 && (num >> (7 * groups)) != 0) groups++;
            for (int i = groups; i > 0; i--) begin
                grp = 8'((num >> (7 * (i - 1))) & 32'h7f);
                if (i > 1) grp = grp | 8'h80;
                q = {q, grp};
            end
            return q;
        endfunction

        // Length octets: short form below 128, otherwise a count octet and big-endian bytes.
        function octet_q_t length_octets(logic [31:0] len);
            octet_q_t q;
            int       n;
            if (len < 128) begin
                q = {q, len[7:0]};
                return q;
            end
            n = 1;
            while (n < 4 && (len >> (8 * n)) != 0) n++;
            q = {q, LEN_LONG_FORM | 8'(n)};
            for (int i = n; i > 0; i--) q = {q, 8'(len >> (8 * (i - 1)))};
            return q;
        endfunction

        function void note_request(logic mode, logic [1:0] kind, logic [1:0] tagging,
                                   logic [1:0] cls, logic [31:0] tnum, logic [62:0] ival,
                                   logic [23:0] slen, logic [7:0] dbyte);
            octet_q_t    body;
            octet_q_t    enc;
            ber_byte_t   item;
            logic [63:0] v;
            logic [31:0] total;
            int          n;
            bit          string_open;
            if (mode == MODE_CONTENT) begin
                // A content byte with no open string is silently dropped.
                if (content_left == 0) begin
                    dropped++;
                    return;
                end
                content_left = content_left - 1;
                content_bytes++;
                item.octet     = dbyte;
                item.run_end   = 1'b1;
                item.value_end = (content_left == 0);
                expected_q = {expected_q, item};
                return;
            end

            // Any start abandons an unfinished string.
            content_left = '0;
            string_open  = 1'b0;
            case (kind)
                KIND_NULL: begin
                    body = {body, ID_NULL};
                    body = {body, 8'h00};
                    total = body.size();
                end
                KIND_INT: begin
                    // Minimal two's-complement: grow until the sign bit of the top octet is clear.
                    v = {1'b0, ival};
                    n = 1;
                    while (n < 8 && (v >> (8 * n - 1)) != 0) n++;
                    body = {body, ID_INTEGER};
                    body = {body, 8'(n)};
                    for (int i = n; i > 0; i--) body = {body, 8'(v >> (8 * (i - 1)))};
                    total = body.size();
                end
                KIND_STRING: begin
                    body = {body, ID_OCTETS};
                    body = {body, length_octets({8'h00, slen})};
                    total = body.size() + slen;
                    string_open = (slen != 0);
                end
                default: begin
                    undefined_kinds++;
                    return;
                end
            endcase
            starts++;

            if (tagging == TAGGING_EXPLICIT) begin
                enc = {tag_octets({cls, 6'b0} | ID_CONSTRUCTED, tnum), length_octets(total), body};
            end else if (tagging == TAGGING_IMPLICIT) begin
                enc = tag_octets({cls, 6'b0}, tnum);
                for (int i = 1; i < body.size(); i++) enc = {enc, body[i]};
            end else begin
                enc = body;
            end

            for (int i = 0; i < enc.size(); i++) begin
                item.octet     = enc[i];
                item.run_end   = (i == enc.size() - 1);
                item.value_end = item.run_end && !string_open;
                expected_q = {expected_q, item};
            end
            if (string_open) content_left = slen;
        endfunction

        function void check_result(logic [7:0] octet, logic run_end, logic value_end);
            ber_byte_t want;
            checked++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected byte %02h last_of_run %0b end_of_value %0b",
                                 octet, run_end, value_end));
                return;
            end
            want = expected_q.pop_front();
            if (want.octet !== octet || want.run_end !== run_end ||
                want.value_end !== value_end) begin
                report($sformatf({"byte %0d: out_byte exp %02h got %02h, last_of_run exp %0b ",
                                  "got %0b, end_of_value exp %0b got %0b"},
                                 checked, want.octet, octet, want.run_end, run_end,
                                 want.value_end, value_end));
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_mode;
    logic [1:0]  s_value_kind;
    logic [1:0]  s_tagging;
    logic [1:0]  s_tag_class;
    logic [31:0] s_tag_number;
    logic [62:0] s_int_value;
    logic [23:0] s_string_length;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_last_of_run;
    logic        m_end_of_value;

    ber_scoreboard sb = new();

    int cycle_count   = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit wind_down     = 1'b0;

    ber_tlv_value_encoder DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_value_kind    (s_value_kind),
        .s_tagging       (s_tagging),
        .s_tag_class     (s_tag_class),
        .s_tag_number    (s_tag_number),
        .s_int_value     (s_int_value),
        .s_string_length (s_string_length),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last_of_run   (m_last_of_run),
        .m_end_of_value  (m_end_of_value)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The watchdog ends a run that hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Both channels are sampled at the clock edge, before any of this edge's updates land.
    // A result taken at an edge always belongs to a request taken at an earlier edge, so
    // the result is checked before the request of the same edge is noted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_result(m_out_byte, m_last_of_run, m_end_of_value);
            end
            if (s_valid && s_ready) begin
                sb.note_request(s_mode, s_value_kind, s_tagging, s_tag_class, s_tag_number,
                                s_int_value, s_string_length, s_data_byte);
            end
        end
    end

    // The idling odds of each side change at random intervals; an odds of zero gives a
    // stretch with no idling at all. Once the run winds down, neither side idles.
    initial begin
        forever begin
            repeat ($urandom_range(40, 160)) @(posedge aclk);
            if (wind_down) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0: src_idle_pct = 0;
                    1: src_idle_pct = 10;
                    2: src_idle_pct = 30;
                    default: src_idle_pct = 60;
                endcase
                case ($urandom_range(0, 3))
                    0: sink_idle_pct = 0;
                    1: sink_idle_pct = 10;
                    2: sink_idle_pct = 30;
                    default: sink_idle_pct = 60;
                endcase
            end
        end
    end

    // The receiver stalls in random bursts, whether or not a byte is waiting,
    // so that stalls fall on header bytes, content bytes and idle cycles alike.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!wind_down && $urandom_range(1, 100) <= sink_idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Presents one request and holds it until it is taken. Valid stays high into the next
    // request unless an idle burst lowers it first.
    task automatic push_request(input logic mode, input logic [1:0] kind,
                                input logic [1:0] tagging, input logic [1:0] cls,
                                input logic [31:0] tnum, input logic [62:0] ival,
                                input logic [23:0] slen, input logic [7:0] dbyte);
        if (!wind_down && $urandom_range(1, 100) <= src_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= mode;
        s_value_kind    <= kind;
        s_tagging       <= tagging;
        s_tag_class     <= cls;
        s_tag_number    <= tnum;
        s_int_value     <= ival;
        s_string_length <= slen;
        s_data_byte     <= dbyte;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // A start request; the content byte field carries noise.
    task automatic start_value(input logic [1:0] kind, input logic [1:0] tagging,
                               input logic [1:0] cls, input logic [31:0] tnum,
                               input logic [62:0] ival, input logic [23:0] slen);
        push_request(MODE_START, kind, tagging, cls, tnum, ival, slen, 8'($urandom));
    endtask

    // Content byte requests; every field but the byte itself carries noise.
    task automatic stream_bytes(input int count);
        for (int i = 0; i < count; i++) begin
            push_request(MODE_CONTENT, 2'($urandom), 2'($urandom), 2'($urandom), $urandom,
                         63'({$urandom, $urandom}), 24'($urandom), 8'($urandom));
        end
    endtask

    // Tag numbers cluster around the one-octet limit and the group boundaries.
    function automatic logic [31:0] rand_tag_number();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 30);
            1: return 32'd31;
            2: return $urandom_range(31, 127);
            3: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Integer magnitudes are spread over every content length from one to eight octets.
    function automatic logic [62:0] rand_int_value();
        logic [63:0] w;
        w = {$urandom, $urandom};
        w = w >> $urandom_range(0, 62);
        return w[62:0];
    endfunction

    function automatic logic [1:0] rand_tagging();
        if ($urandom_range(0, 9) == 0) return TAGGING_UNUSED;
        case ($urandom_range(0, 2))
            0: return TAGGING_NONE;
            1: return TAGGING_IMPLICIT;
            default: return TAGGING_EXPLICIT;
        endcase
    endfunction

    // Most strings are short; a few cross the short-form length limit.
    function automatic logic [23:0] rand_string_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13) return 24'($urandom_range(0, 8));
        if (r < 18) return 24'($urandom_range(9, 40));
        return 24'($urandom_range(120, 140));
    endfunction

    initial begin
        logic [23:0] slen;
        int          pick;

        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_mode          <= MODE_START;
        s_value_kind    <= KIND_NULL;
        s_tagging       <= TAGGING_NONE;
        s_tag_class     <= 2'd0;
        s_tag_number    <= '0;
        s_int_value     <= '0;
        s_string_length <= '0;
        s_data_byte     <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. A content byte right after reset has no open string and is dropped.
        stream_bytes(1);
        start_value(KIND_NULL, TAGGING_NONE, 2'd3, '1, '0, '0);
        start_value(KIND_INT, TAGGING_NONE, 2'd0, '0, 63'd0, '0);
        start_value(KIND_INT, TAGGING_NONE, 2'd0, '0, 63'h7f, '0);
        // The top bit of the only octet is set, so a leading zero octet is needed.
        start_value(KIND_INT, TAGGING_NONE, 2'd0, '0, 63'h80, '0);
        start_value(KIND_INT, TAGGING_NONE, 2'd0, '0, '1, '0);
        start_value(KIND_NULL, TAGGING_IMPLICIT, 2'd2, 32'd0, '0, '0);
        start_value(KIND_INT, TAGGING_IMPLICIT, 2'd1, 32'd30, 63'h8000, '0);
        start_value(KIND_INT, TAGGING_EXPLICIT, 2'd3, 32'd31, 63'h1234, '0);
        start_value(KIND_NULL, TAGGING_EXPLICIT, 2'd3, '1, '0, '0);
        // The longest header: five tag groups around an eight-octet integer.
        start_value(KIND_INT, TAGGING_EXPLICIT, 2'd2, '1, '1, '0);
        // Tagging code three behaves as untagged and ignores the class.
        start_value(KIND_INT, TAGGING_UNUSED, 2'd3, '1, 63'h55aa, '0);
        // An empty string ends the value on its last header byte.
        start_value(KIND_STRING, TAGGING_NONE, 2'd0, '0, '0, 24'd0);
        start_value(KIND_STRING, TAGGING_EXPLICIT, 2'd1, 32'd127, '0, 24'd0);
        start_value(KIND_STRING, TAGGING_IMPLICIT, 2'd2, 32'd128, '0, 24'd3);
        stream_bytes(3);
        // Undefined kind: nothing comes out and any open string is closed.
        start_value(KIND_UNDEF, TAGGING_EXPLICIT, 2'd1, 32'd5, '1, '1);
        start_value(KIND_STRING, TAGGING_NONE, 2'd0, '0, '0, 24'd5);
        stream_bytes(1);
        start_value(KIND_UNDEF, TAGGING_NONE, 2'd0, '0, '0, 24'd5);
        stream_bytes(1);
        // The largest length, abandoned by the next start.
        start_value(KIND_STRING, TAGGING_EXPLICIT, 2'd3, 32'h0fff_ffff, '0, '1);
        stream_bytes(2);
        start_value(KIND_STRING, TAGGING_NONE, 2'd0, '0, '0, 24'd128);
        stream_bytes(1);
        start_value(KIND_STRING, TAGGING_IMPLICIT, 2'd0, 32'd200, '0, 24'd127);
        stream_bytes(2);

        // Random part. Most traffic is complete values with random content; the rest is
        // abandoned strings, undefined kinds and stray content bytes.
        while (sb.counted() < RANDOM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                slen = rand_string_length();
                start_value(KIND_STRING, rand_tagging(), 2'($urandom), rand_tag_number(),
                            rand_int_value(), slen);
                if (slen != 0 && $urandom_range(0, 7) == 0) begin
                    stream_bytes($urandom_range(0, int'(slen) - 1));
                end else begin
                    stream_bytes(int'(slen));
                end
            end else if (pick < 72) begin
                start_value(KIND_INT, rand_tagging(), 2'($urandom), rand_tag_number(),
                            rand_int_value(), 24'($urandom));
            end else if (pick < 84) begin
                start_value(KIND_NULL, rand_tagging(), 2'($urandom), rand_tag_number(),
                            rand_int_value(), 24'($urandom));
            end else if (pick < 89) begin
                start_value(KIND_UNDEF, rand_tagging(), 2'($urandom), rand_tag_number(),
                            rand_int_value(), 24'($urandom));
            end else if (pick < 95) begin
                // A huge string that is cut short; its length reaches every length bit.
                start_value(KIND_STRING, rand_tagging(), 2'($urandom), rand_tag_number(),
                            rand_int_value(), 24'($urandom));
                stream_bytes($urandom_range(0, 3));
            end else begin
                stream_bytes($urandom_range(1, 3));
            end
            if (sb.counted() >= CALM_POINT) wind_down = 1'b1;
        end
        s_valid <= 1'b0;

        // Let the last request land in the scoreboard, drain the expected bytes, then watch
        // a little longer for anything extra.
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Run covered %0d value starts, %0d string content bytes, %0d stray bytes",
                 sb.starts, sb.content_bytes, sb.dropped);
        $display("and %0d undefined kinds; %0d output bytes compared, %0d mismatches.",
                 sb.undefined_kinds, sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

### files.f
sv/bertlv_pkg.sv
sv/bertlv_dp.sv
sv/bertlv_ctrl.sv
sv/ber_tlv_value_encoder.sv
tb/sv/testbench.sv
